// ===== design/idsu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package idsu_pkg;

   localparam int DataWidth = 64;
   localparam int WordWidth = 32;
   localparam int CountWidth = 6;

   typedef enum logic [3:0] {
      OP_SDIV32 = 4'd0,
      OP_UDIV32 = 4'd1,
      OP_SDIV10 = 4'd2,
      OP_UDIV10 = 4'd3,
      OP_SDIV64 = 4'd4,
      OP_SREM64 = 4'd5,
      OP_UDIV64 = 4'd6,
      OP_UREM64 = 4'd7,
      OP_ASR64  = 4'd8,
      OP_LSR64  = 4'd9
   } op_type;

   typedef struct packed {
      logic [3:0]            op;
      logic [DataWidth-1:0]  value_in;
      logic [DataWidth-1:0]  divisor_in;
      logic [CountWidth-1:0] shift_count;
   } req_type;

   typedef struct packed {
      logic [WordWidth-1:0] word_low;
      logic [WordWidth-1:0] word_high;
   } rsp_type;

   // state carried from cell to cell
   typedef struct packed {
      logic                 valid;
      logic [3:0]           op;
      logic                 neg_q;
      logic                 neg_r;
      logic                 zero_div;
      logic [DataWidth-1:0] rem;
      logic [DataWidth-1:0] quo;
      logic [DataWidth-1:0] dvs;
      logic [DataWidth-1:0] shifted;
   } cell_type;

endpackage
`default_nettype wire

// ===== design/idsu_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// One restoring-division step: shift in the next dividend bit, try a subtract.
module idsu_cell (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                advance,
   input  wire idsu_pkg::cell_type  cell_in,
   output idsu_pkg::cell_type       cell_out
);
   import idsu_pkg::*;

   cell_type                 cell_ff;
   cell_type                 cell_in_next;
   logic [DataWidth:0]       trial;
   logic [DataWidth:0]       part;

   always_comb begin
      part = {cell_in.rem, cell_in.quo[DataWidth-1]};
      trial = part - {1'b0, cell_in.dvs};
      cell_in_next = cell_in;
      cell_in_next.quo = {cell_in.quo[DataWidth-2:0], ~trial[DataWidth]};
      cell_in_next.rem = trial[DataWidth] ? part[DataWidth-1:0] : trial[DataWidth-1:0];
   end

   // advance the step result when the pipe moves
   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (advance) begin
         cell_ff <= cell_in_next;
      end
   end

   assign cell_out = cell_ff;
endmodule
`default_nettype wire

// ===== design/integer_divide_and_shift_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Pipelined divider and shifter. One transfer is accepted per cycle while the
// chain is not stalled; each item goes through an entry stage, a chain of 64
// single-bit division cells (one quotient bit per cell) and an output register.
// The chain stalls as a whole while the output register is full and rsp_stall
// is high. Shifts and divide-by-ten travel the same chain; 32-bit divisions run
// on sign- or zero-extended operands through the same 64 cells and are cut
// back to 32 bits at the end.
module integer_divide_and_shift_unit (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_stall,
   input  wire idsu_pkg::req_type req_data,
   output      logic              rsp_valid,
   input  wire logic              rsp_stall,
   output      idsu_pkg::rsp_type rsp_data
);
   import idsu_pkg::*;

   // one quotient bit per cell
   localparam int Stages = DataWidth;

   cell_type             chain [Stages+1];
   cell_type             entry_ff;
   cell_type             entry_in;
   logic                 advance;
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff;
   rsp_type              rsp_in;
   logic                 na, nb, wide, sgn;
   logic [DataWidth-1:0] ma, mb, va, vb;
   logic [DataWidth-1:0] q, r, sh;
   logic [DataWidth:0]   sh_wide;
   cell_type             last;

   assign advance = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   // prepare magnitudes for the chain
   always_comb begin
      wide = req_data.op[2];
      va = wide ? req_data.value_in : {{WordWidth{req_data.value_in[WordWidth-1]}},
                                       req_data.value_in[WordWidth-1:0]};
      vb = req_data.divisor_in;
      if (req_data.op == OP_SDIV10 || req_data.op == OP_UDIV10) begin
         vb = DataWidth'(10);
      end else if (!wide) begin
         vb = {{WordWidth{req_data.divisor_in[WordWidth-1]}},
               req_data.divisor_in[WordWidth-1:0]};
      end
      sgn = req_data.op == OP_SDIV32 || req_data.op == OP_SDIV10 ||
            req_data.op == OP_SDIV64 || req_data.op == OP_SREM64;
      if (!sgn && !wide) begin
         va[DataWidth-1:WordWidth] = '0;
         vb[DataWidth-1:WordWidth] = '0;
      end
      na = sgn && va[DataWidth-1];
      nb = sgn && vb[DataWidth-1];
      ma = na ? -va : va;
      mb = nb ? -vb : vb;
      sh_wide = $signed({req_data.op == OP_ASR64 && req_data.value_in[DataWidth-1],
                         req_data.value_in}) >>> req_data.shift_count;
      sh = sh_wide[DataWidth-1:0];
      entry_in.valid = req_valid;
      entry_in.op = req_data.op;
      entry_in.neg_q = na ^ nb;
      entry_in.neg_r = na;
      entry_in.zero_div = mb == '0;
      entry_in.rem = '0;
      entry_in.quo = ma;
      entry_in.dvs = mb;
      entry_in.shifted = sh;
   end

   // hold the entry stage
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else if (advance) begin
         entry_ff <= entry_in;
      end
   end

   assign chain[0] = entry_ff;

   for (genvar g = 0; g < Stages; g++) begin : g_cell
      idsu_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .cell_in  (chain[g]),
         .cell_out (chain[g+1])
      );
   end

   // fix signs and select the result words
   always_comb begin
      last = chain[Stages];
      q = last.neg_q ? -last.quo : last.quo;
      r = last.neg_r ? -last.rem : last.rem;
      if (last.zero_div) begin
         q = '0;
         r = '0;
      end
      case (last.op)
         OP_SDIV32, OP_UDIV32, OP_SDIV10, OP_UDIV10:
            rsp_in = {q[WordWidth-1:0], r[WordWidth-1:0]};
         OP_SDIV64, OP_UDIV64:
            rsp_in = {q[WordWidth-1:0], q[DataWidth-1:WordWidth]};
         OP_SREM64, OP_UREM64:
            rsp_in = {r[WordWidth-1:0], r[DataWidth-1:WordWidth]};
         OP_ASR64, OP_LSR64:
            rsp_in = {last.shifted[WordWidth-1:0], last.shifted[DataWidth-1:WordWidth]};
         default:
            rsp_in = '0;
      endcase
   end

   // hold the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= last.valid;
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");
   a_stall_link: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without output stall");
   a_chain_hold: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> $stable(chain[Stages].valid))
      else $error("chain moved while stalled");

endmodule
`default_nettype wire
